// ===== rtl/rqms_pkg.sv =====
// shared types and constants for the ring queue with member search
`default_nettype none

package rqms_pkg;

    localparam int RQMS_DEPTH = 16;
    localparam int CAP_W      = 5;
    localparam int VALUE_W    = 31;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        KIND_PUSH = 2'd0,
        KIND_POP  = 2'd1,
        KIND_FIND = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_SCAN,
        S_RESP
    } state_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_PUSH,
        DP_REFUSE,
        DP_POP_EMPTY,
        DP_POP_RD,
        DP_POP_CAP,
        DP_FIND_HIT,
        DP_FIND_MISS,
        DP_SCAN_START,
        DP_SCAN_STEP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       empty;
        logic       full;
        logic       cur_hit;
        logic       scan_done;
        logic       out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/rqms_ctrl.sv =====
// controller state machine sequencing push, pop and find beats
`default_nettype none

module rqms_ctrl
    import rqms_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t stat,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd.op       = DP_NONE;
        cmd.load_out = 1'b0;
        s_tready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = DP_LOAD;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_RESP;
                case (stat.kind)
                    KIND_PUSH: begin
                        cmd.op = stat.full ? DP_REFUSE : DP_PUSH;
                    end
                    KIND_POP: begin
                        if (stat.empty) begin
                            cmd.op = DP_POP_EMPTY;
                        end else begin
                            cmd.op     = DP_POP_RD;
                            state_next = S_POP;
                        end
                    end
                    KIND_FIND: begin
                        if (stat.empty) begin
                            cmd.op = DP_FIND_MISS;
                        end else if (stat.cur_hit) begin
                            cmd.op = DP_FIND_HIT;
                        end else begin
                            cmd.op     = DP_SCAN_START;
                            state_next = S_SCAN;
                        end
                    end
                    default: begin
                        cmd.op = DP_FIND_MISS;
                    end
                endcase
            end
            S_POP: begin
                cmd.op     = DP_POP_CAP;
                state_next = S_RESP;
            end
            S_SCAN: begin
                cmd.op = DP_SCAN_STEP;
                if (stat.scan_done) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/rqms_dp.sv =====
// datapath: slot memory, ring indices, current register, scan and output beat
`default_nettype none

module rqms_dp
    import rqms_pkg::*;
#(
    parameter int DEPTH = RQMS_DEPTH
)
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [CAP_W-1:0]   capacity,
    input  wire ctrl_cmd_t          cmd,
    output dp_status_t              stat,
    input  wire logic [1:0]         in_kind,
    input  wire logic [VALUE_W-1:0] in_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              out_status,
    output logic [VALUE_W-1:0]      out_popped,
    output logic                    out_found
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW = (IW + 1 > CAP_W) ? IW + 1 : CAP_W;
    localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);
    localparam logic [IW:0]   DEPTH_C = (IW + 1)'(DEPTH);

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    logic [1:0]         kind_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [IW-1:0]      ridx_reg, ridx_next;
    logic [IW-1:0]      widx_reg, widx_next;
    logic               empty_reg, empty_next;
    logic [VALUE_W-1:0] cur_reg, cur_next;
    logic [IW-1:0]      scan_idx_reg, scan_idx_next;
    logic [IW:0]        scan_cnt_reg, scan_cnt_next;
    logic               rd_valid_reg, rd_valid_next;

    logic [1:0]         res_status_reg, res_status_next;
    logic [VALUE_W-1:0] res_popped_reg, res_popped_next;
    logic               res_found_reg, res_found_next;

    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic [VALUE_W-1:0] out_popped_reg;
    logic               out_found_reg;

    logic [EW-1:0]      eff_cap;
    logic               full;
    logic               issue_ok;
    logic               hit_now;
    logic               scan_done;
    logic               we;
    logic [IW-1:0]      waddr;
    logic               re;
    logic [IW-1:0]      raddr;

    always_comb begin
        eff_cap = EW'(capacity);
        if (eff_cap == '0) begin
            eff_cap = EW'(1);
        end else if (eff_cap > DEPTH_E) begin
            eff_cap = DEPTH_E;
        end
    end

    function automatic logic [IW-1:0] advance(input logic [IW-1:0] idx,
                                              input logic [EW-1:0] lim);
        logic [EW-1:0] nx;
        nx = EW'(idx) + EW'(1);
        if (nx >= lim) begin
            nx = '0;
        end
        return nx[IW-1:0];
    endfunction

    assign full      = !empty_reg && (ridx_reg == widx_reg);
    assign issue_ok  = (scan_cnt_reg == '0) ||
                       ((scan_idx_reg != widx_reg) && (scan_cnt_reg < DEPTH_C));
    assign hit_now   = rd_valid_reg && (rdata_reg == val_reg);
    assign scan_done = hit_now || (!issue_ok && !rd_valid_reg);

    assign stat.kind      = kind_reg;
    assign stat.empty     = empty_reg;
    assign stat.full      = full;
    assign stat.cur_hit   = (cur_reg == val_reg);
    assign stat.scan_done = scan_done;
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_comb begin
        ridx_next       = ridx_reg;
        widx_next       = widx_reg;
        empty_next      = empty_reg;
        cur_next        = cur_reg;
        scan_idx_next   = scan_idx_reg;
        scan_cnt_next   = scan_cnt_reg;
        rd_valid_next   = 1'b0;
        res_status_next = res_status_reg;
        res_popped_next = res_popped_reg;
        res_found_next  = res_found_reg;
        we              = 1'b0;
        waddr           = widx_reg;
        re              = 1'b0;
        raddr           = ridx_reg;
        case (cmd.op)
            DP_PUSH: begin
                if (empty_reg) begin
                    ridx_next = '0;
                    waddr     = '0;
                end
                we              = 1'b1;
                widx_next       = advance(waddr, eff_cap);
                empty_next      = 1'b0;
                res_status_next = ST_DONE;
                res_popped_next = '0;
                res_found_next  = 1'b0;
            end
            DP_REFUSE: begin
                res_status_next = ST_FULL;
                res_popped_next = '0;
                res_found_next  = 1'b0;
            end
            DP_POP_EMPTY: begin
                res_status_next = ST_EMPTY;
                res_popped_next = '0;
                res_found_next  = 1'b0;
            end
            DP_POP_RD: begin
                re = 1'b1;
            end
            DP_POP_CAP: begin
                cur_next        = rdata_reg;
                ridx_next       = advance(ridx_reg, eff_cap);
                empty_next      = (advance(ridx_reg, eff_cap) == widx_reg);
                res_status_next = ST_DONE;
                res_popped_next = rdata_reg;
                res_found_next  = 1'b0;
            end
            DP_FIND_HIT: begin
                res_status_next = ST_DONE;
                res_popped_next = '0;
                res_found_next  = 1'b1;
            end
            DP_FIND_MISS: begin
                res_status_next = ST_DONE;
                res_popped_next = '0;
                res_found_next  = 1'b0;
            end
            DP_SCAN_START: begin
                scan_idx_next = ridx_reg;
                scan_cnt_next = '0;
            end
            DP_SCAN_STEP: begin
                if (issue_ok && !hit_now) begin
                    re            = 1'b1;
                    raddr         = scan_idx_reg;
                    rd_valid_next = 1'b1;
                    scan_idx_next = advance(scan_idx_reg, eff_cap);
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                if (scan_done) begin
                    res_status_next = ST_DONE;
                    res_popped_next = '0;
                    res_found_next  = hit_now;
                end
            end
            default: begin
            end
        endcase
    end

    // slot memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= val_reg;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == DP_LOAD) begin
            kind_reg <= in_kind;
            val_reg  <= in_value;
        end
        scan_idx_reg   <= scan_idx_next;
        scan_cnt_reg   <= scan_cnt_next;
        res_status_reg <= res_status_next;
        res_popped_reg <= res_popped_next;
        res_found_reg  <= res_found_next;
        if (cmd.load_out) begin
            out_status_reg <= res_status_reg;
            out_popped_reg <= res_popped_reg;
            out_found_reg  <= res_found_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ridx_reg      <= '0;
            widx_reg      <= '0;
            empty_reg     <= 1'b1;
            cur_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            ridx_reg     <= ridx_next;
            widx_reg     <= widx_next;
            empty_reg    <= empty_next;
            cur_reg      <= cur_next;
            rd_valid_reg <= rd_valid_next;
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_popped = out_popped_reg;
    assign out_found  = out_found_reg;

endmodule

`default_nettype wire

// ===== rtl/ring_queue_with_member_search.sv =====
// top level: ring queue of identifiers with push, pop and member find
//
// input beats on s_*: s_tuser holds the operation (push, pop, find), s_tdata
// the identifier. every input beat yields exactly one result beat on m_*:
// m_tuser holds the status (done, push refused when full, pop on empty),
// m_tdata the popped identifier and the found flag.
// one beat is worked on at a time; s_tready is high only while idle.
// push and an empty pop are decided at once, a successful pop first reads its
// slot, and a find is decided at once on an empty queue or a current register
// hit and otherwise scans the queued entries, read from the slot memory one
// per cycle on its single port.
// the result register lets the next beat be accepted while a result waits;
// when m_tready stays low the following result is held back until it drains.
// capacity register at byte address 0 over the apb port, written while idle;
// the block does not enforce this. reset empties the queue, clears the current
// register and sets capacity 16; slot contents are not cleared and no clearing pass is needed.
`default_nettype none

module ring_queue_with_member_search
    import rqms_pkg::*;
#(
    parameter int DEPTH = RQMS_DEPTH
)
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: value[30:0], zero[31]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,
    // s_tuser: kind[1:0]
    input  wire logic [1:0]  s_tuser,
    // m_tdata: popped_value[30:0], found[31]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,
    // m_tuser: status[1:0]
    output logic [1:0]       m_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [CAP_W-1:0]   capacity_reg;
    ctrl_cmd_t          cmd;
    dp_status_t         stat;
    logic [1:0]         out_status;
    logic [VALUE_W-1:0] out_popped;
    logic               out_found;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {{(32 - CAP_W){1'b0}}, capacity_reg};

    rqms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rqms_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .capacity   (capacity_reg),
        .cmd        (cmd),
        .stat       (stat),
        .in_kind    (s_tuser),
        .in_value   (s_tdata[VALUE_W-1:0]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_popped (out_popped),
        .out_found  (out_found)
    );

    assign m_tuser = out_status;
    assign m_tdata = {out_found, out_popped};

endmodule

`default_nettype wire
